### rtl/sbrl_pkg.sv
// ----------------------------------------------------------------------------
// sbrl_pkg: shared types and constants of the serial boot record loader
// Holds the parse phase and result kind codes, the acknowledge byte and the
// result and status structures passed between the parser and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sbrl_pkg;

  // Default load address width and the fixed width of the mem_addr field
  localparam int ADDR_BITS_DEF = 24;
  localparam int MEM_ADDR_W    = 24;
  localparam int BYTE_W        = 8;
  localparam int WORD_W        = 32;

  // Acknowledge byte sent when the stream ends
  localparam logic [BYTE_W-1:0] ACK_BYTE = 8'h10;

  // Parse phase
  typedef enum logic [1:0] {
    PH_LEN  = 2'd0,
    PH_ADDR = 2'd1,
    PH_DATA = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  // Result kind
  typedef enum logic [1:0] {
    KIND_HDR     = 2'd0,
    KIND_WRITE   = 2'd1,
    KIND_ACK     = 2'd2,
    KIND_IGNORED = 2'd3
  } kind_t;

  // One result item
  typedef struct packed {
    kind_t                 kind;
    logic [MEM_ADDR_W-1:0] mem_addr;
    logic [BYTE_W-1:0]     mem_data;
    logic [BYTE_W-1:0]     tx_byte;
  } result_t;

  // Parser status seen by the top level
  typedef struct packed {
    phase_t     phase;
    logic [1:0] byte_pos;
  } status_t;

endpackage

`default_nettype wire

### rtl/serial_boot_record_loader.sv
// A transferred byte is held in the input register, then its result in the result register behind out_valid.
// Throughput: one byte per cycle; the input and result registers move together
// whenever the result register is empty or its result is taken.
// Reset (rst, synchronous): empties both registers and returns the parser to
// expecting length bytes with a cleared write pointer and byte count.
// ----------------------------------------------------------------------------
// serial_boot_record_loader: serial boot record loader top level
// Registers each received byte, parses it through the record state machine
// and registers the result: header taken, memory write, acknowledge or ignore.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module serial_boot_record_loader #(
  parameter int ADDR_BITS = sbrl_pkg::ADDR_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [sbrl_pkg::BYTE_W-1:0]       rx_byte,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [1:0]                             kind,
  output logic [sbrl_pkg::MEM_ADDR_W-1:0]        mem_addr,
  output logic [sbrl_pkg::BYTE_W-1:0]            mem_data,
  output logic [sbrl_pkg::BYTE_W-1:0]            tx_byte
);

  logic                           ir_valid;
  logic [sbrl_pkg::BYTE_W-1:0]    ir_byte;
  sbrl_pkg::result_t              res, res_reg;
  sbrl_pkg::status_t              status;
  logic                           advance;
  logic                           step;

  // Move when the result register is free or being taken
  assign advance  = !out_valid || !out_stall;
  assign step     = ir_valid && advance;
  assign in_stall = ir_valid && !advance;

  // Hold the received byte
  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (advance || !ir_valid) begin
      ir_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ir_byte <= rx_byte;
    end
  end

  sbrl_parser #(
    .ADDR_BITS (ADDR_BITS)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (ir_byte),
    .result  (res),
    .status  (status)
  );

  // Hold the result until transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= ir_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_reg <= res;
    end
  end

  assign kind     = res_reg.kind;
  assign mem_addr = res_reg.mem_addr;
  assign mem_data = res_reg.mem_data;
  assign tx_byte  = res_reg.tx_byte;

`ifndef SYNTHESIS
  // Once ended, the parser stays ended until reset
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    status.phase == sbrl_pkg::PH_DONE |=> status.phase == sbrl_pkg::PH_DONE)
    else $error("parser left the ended phase");

  // Header byte position is idle outside header phases
  a_pos_idle: assert property (@(posedge clk) disable iff (rst)
    (status.phase == sbrl_pkg::PH_DATA || status.phase == sbrl_pkg::PH_DONE)
    |-> status.byte_pos == 2'd0)
    else $error("byte position nonzero outside header phases");

  // A stepped byte always lands in the result register
  a_step_result: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("stepped byte produced no result");

  // An acknowledge carries the ack byte and no write fields
  a_ack_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && res_reg.kind == sbrl_pkg::KIND_ACK
    |-> tx_byte == sbrl_pkg::ACK_BYTE && mem_addr == '0 && mem_data == '0)
    else $error("acknowledge result has wrong fields");
`endif

endmodule

`default_nettype wire

### rtl/sbrl_parser.sv
// ----------------------------------------------------------------------------
// sbrl_parser: record parser state machine
// Holds the phase, header assembly word, remaining byte count and write
// pointer, and forms the result for the current byte combinationally.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbrl_parser #(
  parameter int ADDR_BITS = sbrl_pkg::ADDR_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           step,
  input  wire logic [sbrl_pkg::BYTE_W-1:0]    rx_byte,
  output sbrl_pkg::result_t                   result,
  output sbrl_pkg::status_t                   status
);

  sbrl_pkg::phase_t                  phase, phase_next;
  logic [1:0]                        byte_pos, byte_pos_next;
  logic [sbrl_pkg::WORD_W-1:0]       assembly_word, assembly_word_next;
  logic [sbrl_pkg::WORD_W-1:0]       bytes_left, bytes_left_next;
  logic [ADDR_BITS-1:0]              write_pointer, write_pointer_next;

  logic [sbrl_pkg::WORD_W-1:0]       word_merged;
  logic [sbrl_pkg::WORD_W-1:0]       left_dec;
  logic [sbrl_pkg::WORD_W-1:0]       wp_wide;

  // Merge the new header byte at its position, low byte first
  assign word_merged = assembly_word
                     | (sbrl_pkg::WORD_W'(rx_byte) << {byte_pos, 3'b000});
  assign left_dec    = bytes_left - sbrl_pkg::WORD_W'(1);
  assign wp_wide     = sbrl_pkg::WORD_W'(write_pointer);

  // Hold state, advance on each stepped byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= sbrl_pkg::PH_LEN;
      byte_pos      <= '0;
      assembly_word <= '0;
      bytes_left    <= '0;
      write_pointer <= '0;
    end else if (step) begin
      phase         <= phase_next;
      byte_pos      <= byte_pos_next;
      assembly_word <= assembly_word_next;
      bytes_left    <= bytes_left_next;
      write_pointer <= write_pointer_next;
    end
  end

  // Next state and result for the current byte
  always_comb begin
    phase_next         = phase;
    byte_pos_next      = byte_pos;
    assembly_word_next = assembly_word;
    bytes_left_next    = bytes_left;
    write_pointer_next = write_pointer;
    result.kind        = sbrl_pkg::KIND_HDR;
    result.mem_addr    = '0;
    result.mem_data    = '0;
    result.tx_byte     = '0;
    case (phase)
      sbrl_pkg::PH_LEN, sbrl_pkg::PH_ADDR: begin
        assembly_word_next = word_merged;
        if (byte_pos == 2'd3) begin
          byte_pos_next      = '0;
          assembly_word_next = '0;
          if (phase == sbrl_pkg::PH_LEN) begin
            // Zero length ends the stream
            if (word_merged == '0) begin
              result.kind    = sbrl_pkg::KIND_ACK;
              result.tx_byte = sbrl_pkg::ACK_BYTE;
              phase_next     = sbrl_pkg::PH_DONE;
            end else begin
              bytes_left_next = word_merged;
              phase_next      = sbrl_pkg::PH_ADDR;
            end
          end else begin
            write_pointer_next = word_merged[ADDR_BITS-1:0];
            phase_next         = sbrl_pkg::PH_DATA;
          end
        end else begin
          byte_pos_next = byte_pos + 2'd1;
        end
      end
      sbrl_pkg::PH_DATA: begin
        result.kind        = sbrl_pkg::KIND_WRITE;
        result.mem_addr    = wp_wide[sbrl_pkg::MEM_ADDR_W-1:0];
        result.mem_data    = rx_byte;
        write_pointer_next = write_pointer + ADDR_BITS'(1);
        bytes_left_next    = left_dec;
        // Last data byte: expect the next length
        if (left_dec == '0) begin
          phase_next         = sbrl_pkg::PH_LEN;
          byte_pos_next      = '0;
          assembly_word_next = '0;
        end
      end
      default: begin
        result.kind = sbrl_pkg::KIND_IGNORED;
      end
    endcase
  end

  assign status.phase    = phase;
  assign status.byte_pos = byte_pos;

endmodule

`default_nettype wire

### tb/serial_boot_record_loader_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_boot_record_loader_test: self-checking bench for the boot loader
// Feeds serial byte streams of boot records (length, load address, data) and
// predicts every result (header byte, memory write, acknowledge, ignored
// byte) with a local copy of the parser. Both handshakes idle at random.
// ----------------------------------------------------------------------------

module serial_boot_record_loader_test;

  localparam int ADDR_BITS      = sbrl_pkg::ADDR_BITS_DEF;
  localparam int BYTE_W         = sbrl_pkg::BYTE_W;
  localparam int WORD_W         = sbrl_pkg::WORD_W;
  localparam int MEM_ADDR_W     = sbrl_pkg::MEM_ADDR_W;
  localparam int RANDOM_ITEMS   = 1000;
  localparam int IDLE_PCT       = 24;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 10;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [BYTE_W-1:0]     rx_byte = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            kind;
  logic [MEM_ADDR_W-1:0] mem_addr;
  logic [BYTE_W-1:0]     mem_data;
  logic [BYTE_W-1:0]     tx_byte;

  // Loader state as predicted from the bytes accepted so far
  sbrl_pkg::phase_t      ld_phase = sbrl_pkg::PH_LEN;
  logic [1:0]            hdr_pos = '0;
  logic [WORD_W-1:0]     hdr_word = '0;
  logic [WORD_W-1:0]     bytes_due = '0;
  logic [ADDR_BITS-1:0]  write_ptr = '0;

  sbrl_pkg::result_t     pending_results[$];
  bit                    idle_on = 1'b1;
  int                    bytes_sent = 0;
  int                    records_sent = 0;
  int                    data_sent = 0;
  int                    ignored_sent = 0;
  int                    results_seen = 0;
  int                    mismatches = 0;
  int                    stuck_cycles = 0;

  serial_boot_record_loader #(
    .ADDR_BITS(ADDR_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind(kind),
    .mem_addr(mem_addr),
    .mem_data(mem_data),
    .tx_byte(tx_byte)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Work out the result of one received byte and advance the parser state
  function automatic sbrl_pkg::result_t parse_byte(input logic [BYTE_W-1:0] b);
    sbrl_pkg::result_t r;
    r = '0;
    r.kind = sbrl_pkg::KIND_HDR;
    case (ld_phase)
      sbrl_pkg::PH_LEN, sbrl_pkg::PH_ADDR: begin
        hdr_word = hdr_word | (WORD_W'(b) << (8 * hdr_pos));
        if (hdr_pos == 2'd3) begin
          hdr_pos = '0;
          if (ld_phase == sbrl_pkg::PH_LEN) begin
            if (hdr_word == '0) begin
              r.kind = sbrl_pkg::KIND_ACK;
              r.tx_byte = sbrl_pkg::ACK_BYTE;
              ld_phase = sbrl_pkg::PH_DONE;
            end else begin
              bytes_due = hdr_word;
              ld_phase = sbrl_pkg::PH_ADDR;
            end
          end else begin
            write_ptr = hdr_word[ADDR_BITS-1:0];
            ld_phase = sbrl_pkg::PH_DATA;
          end
          hdr_word = '0;
        end else begin
          hdr_pos = hdr_pos + 2'd1;
        end
      end
      sbrl_pkg::PH_DATA: begin
        r.kind = sbrl_pkg::KIND_WRITE;
        r.mem_addr = MEM_ADDR_W'(write_ptr);
        r.mem_data = b;
        write_ptr = write_ptr + 1'b1;
        bytes_due = bytes_due - 1;
        if (bytes_due == '0) begin
          ld_phase = sbrl_pkg::PH_LEN;
          hdr_pos = '0;
          hdr_word = '0;
        end
      end
      default: begin
        r.kind = sbrl_pkg::KIND_IGNORED;
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // Transfer one byte; called at a falling edge, returns at a falling edge
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(parse_byte(b));
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_word(input logic [WORD_W-1:0] w);
    for (int i = 0; i < 4; i++) send_byte(w[8*i +: 8]);
  endtask

  task automatic send_record(input logic [WORD_W-1:0] len, input logic [WORD_W-1:0] load_addr,
                             input bit random_data);
    logic [BYTE_W-1:0] d;
    send_word(len);
    send_word(load_addr);
    for (int i = 0; i < int'(len); i++) begin
      d = random_data ? BYTE_W'($urandom_range(255)) : BYTE_W'(i);
      send_byte(d);
    end
    records_sent++;
    data_sent += int'(len);
  endtask

  // Single data byte with the field extremes in header and data
  task automatic test_single_byte_record();
    send_word(32'h0000_0001);
    send_word(32'h0000_0000);
    send_byte(8'hFF);
    records_sent++;
    data_sent++;
  endtask

  // Load address above the address width, writes wrapping past the top
  task automatic test_address_wrap();
    send_word(32'h0000_0004);
    send_word(32'hFFFF_FFFE);
    send_byte(8'h00);
    send_byte(8'h55);
    send_byte(8'hAA);
    send_byte(8'hFF);
    records_sent++;
    data_sent += 4;
  endtask

  // Random records, mostly short, a few spanning the second length byte
  task automatic test_random_records();
    logic [WORD_W-1:0] len;
    logic [WORD_W-1:0] load_addr;
    while (bytes_sent < RANDOM_ITEMS) begin
      idle_on = !(bytes_sent >= 400 && bytes_sent < 600);
      len = ($urandom_range(15) == 0) ? WORD_W'($urandom_range(256, 300))
                                      : WORD_W'($urandom_range(1, 16));
      load_addr = $urandom();
      if ($urandom_range(7) == 0)
        load_addr[23:0] = 24'hFF_FFFF - 24'($urandom_range(8));
      send_record(len, load_addr, 1'b1);
    end
    idle_on = 1'b1;
  endtask

  // Zero length word ends the stream with the acknowledge byte
  task automatic test_end_of_stream();
    send_word(32'h0000_0000);
  endtask

  // Every byte after the end is ignored, including a would-be header
  task automatic test_ignore_after_end();
    send_word(32'h0000_0001);
    for (int i = 0; i < 20; i++) begin
      send_byte(BYTE_W'($urandom_range(255)));
    end
    ignored_sent += 24;
  endtask

  // Drive the result stall at random, with a quiet stretch
  always @(negedge clk) begin
    out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
  end

  // Check each result transfer against the oldest prediction
  always @(posedge clk) begin
    sbrl_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d", kind));
      end else begin
        want = pending_results.pop_front();
        if (kind !== want.kind)
          report_mismatch($sformatf("kind got %0d want %0d", kind, want.kind));
        if (mem_addr !== want.mem_addr)
          report_mismatch($sformatf("mem_addr got %h want %h", mem_addr, want.mem_addr));
        if (mem_data !== want.mem_data)
          report_mismatch($sformatf("mem_data got %h want %h", mem_data, want.mem_data));
        if (tx_byte !== want.tx_byte)
          report_mismatch($sformatf("tx_byte got %h want %h", tx_byte, want.tx_byte));
      end
    end
  end

  // End the run when no transfer happens for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results pending",
               stuck_cycles, pending_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_single_byte_record();
    test_address_wrap();
    test_random_records();
    test_end_of_stream();
    test_ignore_after_end();
    in_valid <= 1'b0;

    // Drain the outstanding results, then watch for strays
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d bytes: %0d records, %0d data bytes, end of stream, %0d ignored",
             bytes_sent, records_sent, data_sent, ignored_sent);
    $display("checked %0d results, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/sbrl_pkg.sv
rtl/sbrl_parser.sv
rtl/serial_boot_record_loader.sv
tb/serial_boot_record_loader_test.sv
